// ===== design/iktok_pkg.sv =====
// Shared types and constants for the INI key/value tokenizer.
// Used by the step decoder, the result queue, the top level and the checker.
package iktok_pkg;

    // Default widths of the line counter and the trailing space counter
    localparam int IKT_LINE_BITS  = 24;
    localparam int IKT_SPACE_BITS = 16;

    // Fixed widths of the result fields
    localparam int IKT_LINE_W = 24;
    localparam int IKT_RUN_W  = 16;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Characters the grammar cares about
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;

    typedef enum logic [2:0] {
        KIND_HDR_CHAR  = 3'd0,
        KIND_HDR_DONE  = 3'd1,
        KIND_KEY_CHAR  = 3'd2,
        KIND_VAL_CHAR  = 3'd3,
        KIND_SPACES    = 3'd4,
        KIND_PROP_DONE = 3'd5,
        KIND_ERROR     = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_HDR_JUNK = 2'd1,
        ERR_BAD_LINE = 2'd2
    } err_t;

    // Invalid header shares code zero with "no error"
    localparam err_t ERR_BAD_HDR = ERR_NONE;

    // Parser states, one-hot
    typedef enum logic [10:0] {
        ST_HDR_START     = 11'b000_0000_0001,
        ST_BAD_HDR_START = 11'b000_0000_0010,
        ST_IN_HDR        = 11'b000_0000_0100,
        ST_HDR_TAIL      = 11'b000_0000_1000,
        ST_HDR_JUNK      = 11'b000_0001_0000,
        ST_LINE_START    = 11'b000_0010_0000,
        ST_IN_KEY        = 11'b000_0100_0000,
        ST_WANT_EQ       = 11'b000_1000_0000,
        ST_BAD_LINE      = 11'b001_0000_0000,
        ST_WANT_VAL      = 11'b010_0000_0000,
        ST_IN_VAL        = 11'b100_0000_0000
    } state_t;

    // One result token
    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              ch;
        logic [IKT_RUN_W-1:0]    run;
        logic [IKT_LINE_W-1:0]   line;
        err_t                    err;
        logic                    last;
    } tok_t;

    // Tokens caused by one input word: count and up to two tokens
    typedef struct packed {
        logic [1:0] n;
        tok_t       first;
        tok_t       second;
    } step_res_t;

    function automatic tok_t mk_tok(kind_t k, logic [7:0] c, logic [IKT_RUN_W-1:0] r,
                                    err_t e, logic [IKT_LINE_W-1:0] ln);
        tok_t t;
        t.kind = k;
        t.ch   = c;
        t.run  = r;
        t.line = ln;
        t.err  = e;
        t.last = 1'b0;
        return t;
    endfunction

endpackage

// ===== design/iktok_step.sv =====
// Next-state and token decode for one text byte of the tokenizer.
// Depends on iktok_pkg for states, token types and characters.
module iktok_step import iktok_pkg::*; #(
    parameter int LINE_BITS        = IKT_LINE_BITS,
    parameter int SPACE_COUNT_BITS = IKT_SPACE_BITS
) (
    input  state_t                      state,
    input  logic [LINE_BITS-1:0]        line_cnt,
    input  logic [SPACE_COUNT_BITS-1:0] pending,
    input  logic [7:0]                  text_byte,
    input  logic                        end_of_text,
    output state_t                      state_next,
    output logic [LINE_BITS-1:0]        line_next,
    output logic [SPACE_COUNT_BITS-1:0] pending_next,
    output step_res_t                   res
);

    localparam logic [LINE_BITS-1:0]        LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [SPACE_COUNT_BITS-1:0] SPACE_MAX = {SPACE_COUNT_BITS{1'b1}};

    logic [7:0]                  ch;
    logic                        nl;
    logic                        sp;
    logic [SPACE_COUNT_BITS-1:0] spc_inc;
    logic [IKT_LINE_W-1:0]       line_tag;
    logic [1:0]                  n;
    tok_t                        tok_a;
    tok_t                        tok_b;

    // Decode the byte against the current state
    always_comb begin
        ch       = end_of_text ? CH_NL : text_byte;
        nl       = (ch == CH_NL);
        sp       = (ch == CH_SP);
        spc_inc  = pending + SPACE_COUNT_BITS'(1);
        line_tag = IKT_LINE_W'(line_cnt);

        state_next   = state;
        pending_next = pending;
        line_next    = line_cnt;
        n            = 2'd0;
        tok_a        = '0;
        tok_b        = '0;

        case (state)
            ST_BAD_HDR_START: begin
                if (nl) state_next = ST_HDR_START;
            end
            ST_IN_HDR: begin
                if (nl) begin
                    tok_a      = mk_tok(KIND_ERROR, 8'd0, '0, ERR_BAD_HDR, line_tag);
                    n          = 2'd1;
                    state_next = ST_LINE_START;
                end else if (ch == CH_RBRACK) begin
                    tok_a      = mk_tok(KIND_HDR_DONE, 8'd0, '0, ERR_NONE, line_tag);
                    n          = 2'd1;
                    state_next = ST_HDR_TAIL;
                end else begin
                    tok_a = mk_tok(KIND_HDR_CHAR, ch, '0, ERR_NONE, line_tag);
                    n     = 2'd1;
                end
            end
            ST_HDR_TAIL: begin
                if (nl) begin
                    state_next = ST_LINE_START;
                end else if (!sp) begin
                    tok_a      = mk_tok(KIND_ERROR, 8'd0, '0, ERR_HDR_JUNK, line_tag);
                    n          = 2'd1;
                    state_next = ST_HDR_JUNK;
                end
            end
            ST_HDR_JUNK, ST_BAD_LINE: begin
                if (nl) state_next = ST_LINE_START;
            end
            ST_LINE_START: begin
                if (ch == CH_LBRACK) begin
                    state_next = ST_IN_HDR;
                end else if (!sp && !nl) begin
                    tok_a      = mk_tok(KIND_KEY_CHAR, ch, '0, ERR_NONE, line_tag);
                    n          = 2'd1;
                    state_next = ST_IN_KEY;
                end
            end
            ST_IN_KEY: begin
                if (sp) begin
                    state_next = ST_WANT_EQ;
                end else if (ch == CH_EQ) begin
                    state_next = ST_WANT_VAL;
                end else if (nl) begin
                    tok_a      = mk_tok(KIND_ERROR, 8'd0, '0, ERR_BAD_LINE, line_tag);
                    n          = 2'd1;
                    state_next = ST_LINE_START;
                end else begin
                    tok_a = mk_tok(KIND_KEY_CHAR, ch, '0, ERR_NONE, line_tag);
                    n     = 2'd1;
                end
            end
            ST_WANT_EQ: begin
                if (ch == CH_EQ) begin
                    state_next = ST_WANT_VAL;
                end else if (nl) begin
                    tok_a      = mk_tok(KIND_ERROR, 8'd0, '0, ERR_BAD_LINE, line_tag);
                    n          = 2'd1;
                    state_next = ST_LINE_START;
                end else if (!sp) begin
                    tok_a      = mk_tok(KIND_ERROR, 8'd0, '0, ERR_BAD_LINE, line_tag);
                    n          = 2'd1;
                    state_next = ST_BAD_LINE;
                end
            end
            ST_WANT_VAL: begin
                if (nl) begin
                    tok_a      = mk_tok(KIND_PROP_DONE, 8'd0, '0, ERR_NONE, line_tag);
                    n          = 2'd1;
                    state_next = ST_LINE_START;
                end else if (!sp) begin
                    pending_next = '0;
                    tok_a        = mk_tok(KIND_VAL_CHAR, ch, '0, ERR_NONE, line_tag);
                    n            = 2'd1;
                    state_next   = ST_IN_VAL;
                end
            end
            ST_IN_VAL: begin
                if (nl) begin
                    // drop trailing spaces at end of line
                    pending_next = '0;
                    tok_a        = mk_tok(KIND_PROP_DONE, 8'd0, '0, ERR_NONE, line_tag);
                    n            = 2'd1;
                    state_next   = ST_LINE_START;
                end else if (sp) begin
                    // flush the run once the counter is full
                    if (spc_inc == SPACE_MAX) begin
                        tok_a = mk_tok(KIND_SPACES, 8'd0, IKT_RUN_W'(spc_inc), ERR_NONE,
                                       line_tag);
                        n            = 2'd1;
                        pending_next = '0;
                    end else begin
                        pending_next = spc_inc;
                    end
                end else if (pending != '0) begin
                    tok_a = mk_tok(KIND_SPACES, 8'd0, IKT_RUN_W'(pending), ERR_NONE, line_tag);
                    tok_b = mk_tok(KIND_VAL_CHAR, ch, '0, ERR_NONE, line_tag);
                    n            = 2'd2;
                    pending_next = '0;
                end else begin
                    tok_a = mk_tok(KIND_VAL_CHAR, ch, '0, ERR_NONE, line_tag);
                    n     = 2'd1;
                end
            end
            default: begin
                // header start
                if (ch == CH_LBRACK) begin
                    state_next = ST_IN_HDR;
                end else if (!sp && !nl) begin
                    tok_a      = mk_tok(KIND_ERROR, 8'd0, '0, ERR_BAD_HDR, line_tag);
                    n          = 2'd1;
                    state_next = ST_BAD_HDR_START;
                end else begin
                    state_next = ST_HDR_START;
                end
            end
        endcase

        // End of text returns to reset; a newline advances the saturating line count
        if (end_of_text) begin
            state_next   = ST_HDR_START;
            line_next    = LINE_BITS'(1);
            pending_next = '0;
        end else if (nl && (line_cnt != LINE_MAX)) begin
            line_next = line_cnt + LINE_BITS'(1);
        end

        // Mark the last token of this word
        if (n == 2'd2) begin
            tok_b.last = 1'b1;
        end else begin
            tok_a.last = 1'b1;
        end

        res.n      = n;
        res.first  = tok_a;
        res.second = tok_b;
    end

endmodule

// ===== design/iktok_queue.sv =====
// Result queue of the tokenizer: takes up to two tokens a cycle, gives one.
// Depends on iktok_pkg for the token types and the queue geometry.
module iktok_queue import iktok_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  step_res_t              push,
    input  logic                   pop,
    output tok_t                   head,
    output logic                   not_empty,
    output logic [QUEUE_CNT_W-1:0] room
);

    tok_t                   q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign head      = q_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign room      = QUEUE_CNT_W'(QUEUE_DEPTH) - count_reg;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(do_pop);
        count_next  = count_reg + QUEUE_CNT_W'(push.n) - QUEUE_CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming tokens in order
    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2) begin
            q_reg[wr_ptr_reg + QUEUE_PTR_W'(1)] <= push.second;
        end
    end

endmodule

// ===== design/ini_key_value_tokenizer.sv =====
// Top level of the INI key/value tokenizer: input register, step decode, result queue.
// Depends on iktok_pkg, iktok_step and iktok_queue.
//
// Takes one text byte per word on the slave stream (tlast marks end of text, which acts
// as a final newline and then resets the parser and the line count to 1) and gives one
// token per word on the master stream, with the token kind on m_axis_tuser. A byte word
// is taken every cycle while the queue has room; most bytes give zero or one token, a value
// byte after held-back spaces gives two (space run, then the character), and the master
// side delivers one token per cycle, so sustained rate is one byte per cycle as long as
// tokens are drained at one per cycle. A registered byte waits in the input register
// until the four-entry result queue has room for all its tokens.
// m_axis_tlast marks the last token caused by one byte. Key or header characters sent
// before an error token on the same line are to be thrown away by the consumer.
module ini_key_value_tokenizer import iktok_pkg::*; #(
    parameter int LINE_BITS        = IKT_LINE_BITS,
    parameter int SPACE_COUNT_BITS = IKT_SPACE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] char_value, [23:8] space_run, [47:24] line, [49:48] error_code, [55:50] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_item
);

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [7:0]                  in_byte_reg;
    logic                        in_eot_reg;
    state_t                      state_reg;
    state_t                      state_next;
    logic [LINE_BITS-1:0]        line_reg;
    logic [LINE_BITS-1:0]        line_next;
    logic [SPACE_COUNT_BITS-1:0] pending_reg;
    logic [SPACE_COUNT_BITS-1:0] pending_next;
    step_res_t                   res;
    step_res_t                   push;
    logic                        consume;
    logic                        s_accept;
    tok_t                        head;
    logic                        q_not_empty;
    logic [QUEUE_CNT_W-1:0]      q_room;

    // Decode the registered byte
    iktok_step #(
        .LINE_BITS        (LINE_BITS),
        .SPACE_COUNT_BITS (SPACE_COUNT_BITS)
    ) u_step (
        .state        (state_reg),
        .line_cnt     (line_reg),
        .pending      (pending_reg),
        .text_byte    (in_byte_reg),
        .end_of_text  (in_eot_reg),
        .state_next   (state_next),
        .line_next    (line_next),
        .pending_next (pending_next),
        .res          (res)
    );

    // Retire the byte only when the queue can take all its tokens
    assign consume       = in_valid_reg && (QUEUE_CNT_W'(res.n) <= q_room);
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_accept ? 1'b1 : (consume ? 1'b0 : in_valid_reg);

    always_comb begin
        push   = res;
        push.n = consume ? res.n : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_HDR_START;
            line_reg     <= LINE_BITS'(1);
            pending_reg  <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (consume) begin
                state_reg   <= state_next;
                line_reg    <= line_next;
                pending_reg <= pending_next;
            end
        end
    end

    // Hold the input word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
            in_eot_reg  <= s_axis_tlast;
        end
    end

    iktok_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_axis_tready),
        .head      (head),
        .not_empty (q_not_empty),
        .room      (q_room)
    );

    assign m_axis_tvalid = q_not_empty;
    assign m_axis_tdata  = {6'b000000, head.err, head.line, head.run, head.ch};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule

// ===== design/iktok_checker.sv =====
// Port-level checks for the INI key/value tokenizer, bound to its top level.
// Depends on iktok_pkg for the token kind codes.
module iktok_checker import iktok_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic [2:0] kind;
    logic [7:0] ch;
    logic [1:0] err;

    assign kind = m_axis_tuser;
    assign ch   = m_axis_tdata[7:0];
    assign err  = m_axis_tdata[49:48];

    // A stalled token holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled token changed");

    // Nothing comes out in the cycle after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("token valid after reset");

    // Only a space run can be followed by another token of the same byte
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> kind == KIND_SPACES)
        else $error("non-last token is not a space run");

    // Error tokens carry no character and a defined code
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && kind == KIND_ERROR |-> ch == 8'd0 && err != 2'd3)
        else $error("malformed error token");

    // Only error tokens carry a nonzero code
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && kind != KIND_ERROR |-> err == ERR_NONE)
        else $error("error code on a non-error token");

endmodule

bind ini_key_value_tokenizer iktok_checker u_iktok_checker (.*);
